// ===== rtl/core/lpd_pkg.sv =====
// Package for the length-prefixed deframer: phase codes, item kinds,
// register indexes, reset values and the result item type.
// No dependencies; the parser, output buffer and top level import it.
package lpd_pkg;

   // header and payload phases
   localparam logic [2:0] PH_LEN   = 3'd0;
   localparam logic [2:0] PH_TYPE  = 3'd1;
   localparam logic [2:0] PH_JSIZE = 3'd2;
   localparam logic [2:0] PH_EMIT  = 3'd3;
   localparam logic [2:0] PH_SKIP  = 3'd4;

   // result item kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_JSON   = 2'd1;
   localparam logic [1:0] KIND_BIN    = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_LEN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JSON_LEN  = 1'd1;

   localparam logic [31:0] MAX_FRAME_LEN_RESET = 32'h0100_0000;
   localparam logic [31:0] MAX_JSON_LEN_RESET  = 32'h0100_0000;

   // fixed header geometry
   localparam logic [31:0] HDR_TAIL_BYTES = 32'd6;   // type plus JSON size
   localparam logic [1:0]  LEN_LAST_BYTE  = 2'd3;
   localparam logic [1:0]  TYPE_LAST_BYTE = 2'd1;
   localparam logic [1:0]  JSIZE_LAST_BYTE = 2'd3;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [15:0] msg_type;
      logic [31:0] json_len;
      logic [31:0] bin_len;
      logic [7:0]  data_byte;
      logic        last;
   } lpd_result_type;

endpackage

// ===== rtl/core/lpd_if.sv =====
// Valid/ready channel interfaces of the deframer: received bytes in,
// result items out. No dependencies.
interface lpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [15:0] msg_type;
   logic [31:0] json_len;
   logic [31:0] bin_len;
   logic [7:0]  data_byte;
   logic        last;

   modport source (output valid, output item_kind, output msg_type, output json_len,
                   output bin_len, output data_byte, output last, input ready);
   modport sink (input valid, input item_kind, input msg_type, input json_len,
                 input bin_len, input data_byte, input last, output ready);
endinterface

// ===== rtl/core/lpd_parser.sv =====
// Header parser and payload tagger: one byte per transfer, at most one
// result item per byte. Depends on lpd_pkg.
module lpd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid_i,
   input  logic [7:0]             byte_i,
   input  logic [31:0]            max_frame_len_i,
   input  logic [31:0]            max_json_len_i,
   output logic                   res_valid_o,
   output lpd_pkg::lpd_result_type res_o
);
   import lpd_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] frame_len_ff, frame_len_in;
   logic [31:0] payload_ff, payload_in;
   logic [15:0] frame_type_ff, frame_type_in;
   logic [31:0] json_ff, json_in;
   logic [31:0] bin_ff, bin_in;
   logic [31:0] remain_ff, remain_in;

   logic [31:0] len_shift;
   logic [31:0] json_shift;
   logic [31:0] consumed;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      frame_len_in  = frame_len_ff;
      payload_in    = payload_ff;
      frame_type_in = frame_type_ff;
      json_in       = json_ff;
      bin_in        = bin_ff;
      remain_in     = remain_ff;
      res_valid_o   = 1'b0;
      res_o         = '0;
      res_o.msg_type = frame_type_ff;
      res_o.json_len = json_ff;
      res_o.bin_len  = bin_ff;

      // restart the length field when no length byte is pending
      len_shift  = (phase_ff == PH_LEN && count_ff != 2'd0) ?
                   {frame_len_ff[23:0], byte_i} : {24'd0, byte_i};
      json_shift = {json_ff[23:0], byte_i};
      consumed   = payload_ff - remain_ff;

      if (byte_valid_i) begin
         case (phase_ff)
            PH_TYPE: begin
               frame_type_in = {frame_type_ff[7:0], byte_i};
               count_in      = count_ff + 2'd1;
               if (count_ff == TYPE_LAST_BYTE) begin
                  count_in = 2'd0;
                  json_in  = '0;
                  phase_in = PH_JSIZE;
               end
            end
            PH_JSIZE: begin
               json_in  = json_shift;
               count_in = count_ff + 2'd1;
               if (count_ff == JSIZE_LAST_BYTE) begin
                  count_in  = 2'd0;
                  remain_in = payload_ff;
                  bin_in    = payload_ff - json_shift;
                  if (json_shift > payload_ff || json_shift > max_json_len_i) begin
                     phase_in = (payload_ff == '0) ? PH_LEN : PH_SKIP;
                  end else begin
                     phase_in        = (payload_ff == '0) ? PH_LEN : PH_EMIT;
                     res_valid_o     = 1'b1;
                     res_o.item_kind = KIND_HEADER;
                     res_o.json_len  = json_shift;
                     res_o.bin_len   = payload_ff - json_shift;
                     res_o.last      = (payload_ff == '0);
                  end
               end
            end
            PH_EMIT: begin
               remain_in       = remain_ff - 32'd1;
               res_valid_o     = 1'b1;
               res_o.item_kind = (consumed < json_ff) ? KIND_JSON : KIND_BIN;
               res_o.data_byte = byte_i;
               res_o.last      = (remain_ff == 32'd1);
               if (remain_ff == 32'd1) begin
                  phase_in = PH_LEN;
               end
            end
            PH_SKIP: begin
               if (remain_ff != '0) begin
                  remain_in = remain_ff - 32'd1;
               end
               if (remain_ff <= 32'd1) begin
                  phase_in = PH_LEN;
               end
            end
            default: begin
               // length field, also recovery from an undefined phase
               frame_len_in = len_shift;
               count_in     = (phase_ff == PH_LEN) ? count_ff + 2'd1 : 2'd1;
               phase_in     = PH_LEN;
               if (phase_ff == PH_LEN && count_ff == LEN_LAST_BYTE) begin
                  count_in = 2'd0;
                  if (len_shift < HDR_TAIL_BYTES || len_shift > max_frame_len_i) begin
                     frame_len_in = '0;
                  end else begin
                     payload_in    = len_shift - HDR_TAIL_BYTES;
                     frame_type_in = '0;
                     phase_in      = PH_TYPE;
                  end
               end
            end
         endcase
      end
   end

   // hold control state under reset, advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         count_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      frame_len_ff  <= frame_len_in;
      payload_ff    <= payload_in;
      frame_type_ff <= frame_type_in;
      json_ff       <= json_in;
      bin_ff        <= bin_in;
      remain_ff     <= remain_in;
   end

   // the emit phase never runs with nothing left to count
   a_emit_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_EMIT |-> remain_ff != '0)
      else $error("emit phase with zero bytes remaining");

   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      res_valid_o |-> (phase_ff == PH_EMIT || phase_ff == PH_JSIZE))
      else $error("result outside header end or payload emit");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      res_valid_o && res_o.last |=> phase_ff == PH_LEN)
      else $error("last item did not return to length search");

endmodule

// ===== rtl/core/lpd_out_buf.sv =====
// Result register with a skid entry, so a new byte can be taken while a
// finished item waits downstream. Depends on lpd_pkg.
module lpd_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_i,
   input  lpd_pkg::lpd_result_type push_data_i,
   output logic                    space_o,
   output logic                    out_valid_o,
   input  logic                    out_ready_i,
   output lpd_pkg::lpd_result_type out_data_o
);
   import lpd_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   lpd_result_type out_data_ff, out_data_in;
   lpd_result_type skid_data_ff, skid_data_in;
   logic           pop;

   assign pop         = out_valid_ff && out_ready_i;
   assign space_o     = !skid_valid_ff;
   assign out_valid_o = out_valid_ff;
   assign out_data_o  = out_data_ff;

   // refill from skid first, else take the new item or park it
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_i) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data_i;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data_i;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_i && skid_valid_ff))
      else $error("item pushed while both entries full");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready_i |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result changed");

endmodule

// ===== rtl/core/length_prefixed_deframer_unit.sv =====
// Length-prefixed deframer, top level.
// Each result item is registered in the output register, or in the skid entry while that is held.
// Throughput: one byte per cycle while input ready is high; the parser state registers each byte's update,
// and the two-entry output buffer holds input ready low only while both entries are full.
// Reset (synchronous): length search, empty output buffer, both limits at 16777216.
module length_prefixed_deframer_unit (
   input  logic                           clock,
   input  logic                           reset,
   lpd_req_if.sink                        req_chan,
   lpd_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [lpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);
   import lpd_pkg::*;

   logic [31:0]    max_frame_len_ff;
   logic [31:0]    max_json_len_ff;
   logic           space;
   logic           accept;
   logic           res_valid;
   lpd_result_type res;
   lpd_result_type out_data;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= MAX_FRAME_LEN_RESET;
         max_json_len_ff  <= MAX_JSON_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_FRAME_LEN: max_frame_len_ff <= csr_wdata;
            CSR_MAX_JSON_LEN:  max_json_len_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lpd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .byte_valid_i    (accept),
      .byte_i          (req_chan.rx_byte),
      .max_frame_len_i (max_frame_len_ff),
      .max_json_len_i  (max_json_len_ff),
      .res_valid_o     (res_valid),
      .res_o           (res)
   );

   lpd_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push_i      (res_valid),
      .push_data_i (res),
      .space_o     (space),
      .out_valid_o (rsp_chan.valid),
      .out_ready_i (rsp_chan.ready),
      .out_data_o  (out_data)
   );

   assign rsp_chan.item_kind = out_data.item_kind;
   assign rsp_chan.msg_type  = out_data.msg_type;
   assign rsp_chan.json_len  = out_data.json_len;
   assign rsp_chan.bin_len   = out_data.bin_len;
   assign rsp_chan.data_byte = out_data.data_byte;
   assign rsp_chan.last      = out_data.last;

endmodule
